[design/dpod_pkg.sv]
package dpod_pkg;

   localparam int DAY_W = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W = 14;
   localparam int SHIFTED_YEAR_W = YEAR_W + 1;
   localparam int NUM_W = 23;
   localparam int DAYS_W = 22;
   localparam int DOY_W = 9;
   localparam int CENTURY_W = 8;

   localparam int YEAR_OFFSET = 400;
   localparam int DAYS_PER_YEAR = 365;
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP_100 = ((1 << RECIP_SHIFT) + 99) / 100;
   localparam logic [DAYS_W-1:0] DAYS_MAX = '1;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic [DAY_W-1:0]   a_start_day;
      logic [MONTH_W-1:0] a_start_month;
      logic [YEAR_W-1:0]  a_start_year;
      logic [DAY_W-1:0]   a_end_day;
      logic [MONTH_W-1:0] a_end_month;
      logic [YEAR_W-1:0]  a_end_year;
      logic [DAY_W-1:0]   b_start_day;
      logic [MONTH_W-1:0] b_start_month;
      logic [YEAR_W-1:0]  b_start_year;
      logic [DAY_W-1:0]   b_end_day;
      logic [MONTH_W-1:0] b_end_month;
      logic [YEAR_W-1:0]  b_end_year;
   } req_type;

   typedef struct packed {
      logic [DAYS_W-1:0] overlap_days;
      logic              overlaps;
      logic              bad_date;
   } rsp_type;

   typedef struct packed {
      logic             ok;
      logic [NUM_W-1:0] number;
   } date_info_type;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
         MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Days before the first of the month, counting years from March.
   function automatic logic [DOY_W-1:0] month_base(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] base;
      case (month)
         MONTH_MAR: base = 9'd0;
         MONTH_APR: base = 9'd31;
         MONTH_MAY: base = 9'd61;
         MONTH_JUN: base = 9'd92;
         MONTH_JUL: base = 9'd122;
         MONTH_AUG: base = 9'd153;
         MONTH_SEP: base = 9'd184;
         MONTH_OCT: base = 9'd214;
         MONTH_NOV: base = 9'd245;
         MONTH_DEC: base = 9'd275;
         MONTH_JAN: base = 9'd306;
         MONTH_FEB: base = 9'd337;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

[design/dpod_date_conv.sv]
module dpod_date_conv (
   input  dpod_pkg::date_type      date,
   output dpod_pkg::date_info_type info
);
   import dpod_pkg::*;

   localparam int YPROD_W = YEAR_W + RECIP_SHIFT - 6;
   localparam int SPROD_W = SHIFTED_YEAR_W + RECIP_SHIFT - 6;

   logic [YPROD_W-1:0]        year_prod;
   logic [CENTURY_W-1:0]      year_century;
   logic                      div4;
   logic                      div100;
   logic                      div400;
   logic                      leap;
   logic [DAY_W-1:0]          len;
   logic                      early_month;
   logic [SHIFTED_YEAR_W-1:0] shifted_year;
   logic [SPROD_W-1:0]        shifted_prod;
   logic [CENTURY_W-1:0]      shifted_century;
   logic [NUM_W-1:0]          number;

   always_comb begin
      year_prod = YPROD_W'(date.year) * YPROD_W'(RECIP_100);
      year_century = CENTURY_W'(year_prod >> RECIP_SHIFT);
      div4 = (date.year[1:0] == 2'b00);
      div100 = (YEAR_W'(year_century) * YEAR_W'(100) == date.year);
      div400 = div100 && (year_century[1:0] == 2'b00);
      leap = div400 || (div4 && !div100);
      len = month_length(date.month, leap);

      early_month = (date.month <= MONTH_FEB);
      shifted_year = SHIFTED_YEAR_W'(date.year) + SHIFTED_YEAR_W'(YEAR_OFFSET)
                     - SHIFTED_YEAR_W'(early_month);
      shifted_prod = SPROD_W'(shifted_year) * SPROD_W'(RECIP_100);
      shifted_century = CENTURY_W'(shifted_prod >> RECIP_SHIFT);

      number = NUM_W'(shifted_year) * NUM_W'(DAYS_PER_YEAR)
               + NUM_W'(shifted_year >> 2)
               - NUM_W'(shifted_century)
               + NUM_W'(shifted_century >> 2)
               + NUM_W'(month_base(date.month))
               + NUM_W'(date.day) - NUM_W'(1);

      info.ok = (date.month >= MONTH_JAN) && (date.month <= MONTH_DEC)
                && (date.day != '0) && (date.day <= len);
      info.number = number;
   end

endmodule

[design/dpod_overlap.sv]
module dpod_overlap (
   input  dpod_pkg::date_info_type a_start,
   input  dpod_pkg::date_info_type a_end,
   input  dpod_pkg::date_info_type b_start,
   input  dpod_pkg::date_info_type b_end,
   input  logic                    include_end_day,
   output dpod_pkg::rsp_type       rsp
);
   import dpod_pkg::*;

   logic [NUM_W-1:0] lo;
   logic [NUM_W-1:0] hi;
   logic             bad;
   logic [NUM_W:0]   count;

   always_comb begin
      lo = (a_start.number > b_start.number) ? a_start.number : b_start.number;
      hi = (a_end.number < b_end.number) ? a_end.number : b_end.number;
      bad = !(a_start.ok && a_end.ok && b_start.ok && b_end.ok);
      count = (NUM_W + 1)'(hi) - (NUM_W + 1)'(lo) + (NUM_W + 1)'(include_end_day);
      rsp.bad_date = bad;
      rsp.overlaps = 1'b0;
      rsp.overlap_days = '0;
      if (!bad && (lo <= hi)) begin
         rsp.overlaps = 1'b1;
         if (count > (NUM_W + 1)'(DAYS_MAX)) begin
            rsp.overlap_days = DAYS_MAX;
         end else begin
            rsp.overlap_days = DAYS_W'(count);
         end
      end
   end

endmodule

[design/date_period_overlap_days.sv]
// Requests pass through an input register and then a result register; throughput
// is one transaction per cycle while rsp_ready does not stall the result register.
// The date conversion and overlap logic between the two registers set the clock
// period. Reset is synchronous and active high: it empties both stages and sets
// include_end_day to 1.
module date_period_overlap_days (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dpod_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dpod_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);
   import dpod_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   req_type       in_data_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   logic          include_end_day_ff;
   logic          out_advance;
   date_info_type a_start_info;
   date_info_type a_end_info;
   date_info_type b_start_info;
   date_info_type b_end_info;
   rsp_type       rsp_result;

   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_advance;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !out_advance);
   assign rsp_valid_in = in_valid_ff ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   dpod_date_conv u_a_start (
      .date ({in_data_ff.a_start_day, in_data_ff.a_start_month, in_data_ff.a_start_year}),
      .info (a_start_info)
   );

   dpod_date_conv u_a_end (
      .date ({in_data_ff.a_end_day, in_data_ff.a_end_month, in_data_ff.a_end_year}),
      .info (a_end_info)
   );

   dpod_date_conv u_b_start (
      .date ({in_data_ff.b_start_day, in_data_ff.b_start_month, in_data_ff.b_start_year}),
      .info (b_start_info)
   );

   dpod_date_conv u_b_end (
      .date ({in_data_ff.b_end_day, in_data_ff.b_end_month, in_data_ff.b_end_year}),
      .info (b_end_info)
   );

   dpod_overlap u_overlap (
      .a_start         (a_start_info),
      .a_end           (a_end_info),
      .b_start         (b_start_info),
      .b_end           (b_end_info),
      .include_end_day (include_end_day_ff),
      .rsp             (rsp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         include_end_day_ff <= 1'b1;
      end else if (csr_write_enable) begin
         include_end_day_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         if (out_advance) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (in_valid_ff && out_advance) begin
         rsp_ff <= rsp_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("Accepted request did not load the input register.");

   a_stage_moves : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_advance) |=> rsp_valid_ff)
      else $error("Input stage advanced without producing a result.");

   a_inclusive_count : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_advance && include_end_day_ff)
      |=> (rsp_ff.overlaps == (rsp_ff.overlap_days != '0)))
      else $error("Inclusive count disagrees with the overlap flag.");

endmodule
